// ----- design/lkv_pkg.sv -----
// Shared types and constants for the LRU key-value cache core.
// Used by lkv_cell and lru_key_value_cache_core; depends on nothing.
package lkv_pkg;

  localparam int ENTRIES = 16;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int CAP_W   = 5;
  localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  // Request word as it arrives on the command port.
  typedef struct packed {
    logic               command;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } lkv_req_t;

  // Result word returned for every get.
  typedef struct packed {
    logic               found;
    logic signed [31:0] read_value;
  } lkv_rsp_t;

  // Contents of one cell of the recency chain.
  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [31:0] value;
  } lkv_entry_t;

  // Per-cell control: capture the key match, or load from the left neighbour.
  typedef struct packed {
    logic capture;
    logic shift;
  } lkv_cell_ctrl_t;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } lkv_state_t;

endpackage

// ----- design/lru_key_value_cache_core.sv -----
// Top level of the LRU key-value cache: a chain of cells ordered by recency.
// Depends on lkv_pkg and lkv_cell.
//
//  channel   signals                       direction  handshake
//  request   start, busy, req              in         taken when start and not busy
//  result    done, rsp                     out        one cycle, marked by done
//  config    cfg_valid, cfg_ready, cfg_data in        written when valid and ready
//
// For each request the key is first compared in every cell when the word is
// taken, and the chain then shifts in the update state. The result of a
// get appears on rsp with done for one cycle after that, while the next word can
// already be taken. The receiver cannot stall. cfg_ready is low while a word is
// offered or being updated. Reset clears the valid marks, the occupied count
// and sets the capacity to sixteen; no clearing pass is needed.
module lru_key_value_cache_core import lkv_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  lkv_req_t         req,
  output logic             done,
  output lkv_rsp_t         rsp,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data
);

  lkv_state_t       state, state_next;
  logic [CAP_W-1:0] capacity;
  logic [CNT_W-1:0] count;
  lkv_req_t         cur;
  logic             update;
  logic             capture;

  lkv_entry_t       entries [ENTRIES];
  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] hit_above;
  logic [ENTRIES-1:0] shift;
  lkv_entry_t       new_entry;
  logic             any_hit;
  logic [31:0]      hit_value;
  logic [CMP_W-1:0] cap_ext, eff_cap, count_ext, limit;
  logic             evict;
  logic             is_put;

  // The capacity only changes while no word is in progress.
  assign cfg_ready = !busy && !start;
  assign capture   = start && !busy;

  // Capacity register.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (capture) state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // State outputs.
  always_comb begin
    busy   = 1'b0;
    update = 1'b0;
    unique case (state)
      ST_IDLE:   busy = 1'b0;
      ST_UPDATE: begin
        busy   = 1'b1;
        update = 1'b1;
      end
      default:   busy = 1'b0;
    endcase
  end

  // Hold the request word for the update cycle.
  always_ff @(posedge clk) begin
    if (capture) begin
      cur <= req;
    end
  end

  // Effective capacity, clamped to one up to the number of cells.
  always_comb begin
    cap_ext   = CMP_W'(capacity);
    count_ext = CMP_W'(count);
    if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
    evict = count_ext >= eff_cap;
    limit = evict ? (count_ext - CMP_W'(1)) : count_ext;
  end

  // Value of the matching cell; at most one cell can match.
  always_comb begin
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match[i]) begin
        hit_value = hit_value | entries[i].value;
      end
    end
  end

  assign any_hit = |match;
  assign is_put  = (cur.command == CMD_PUT);

  // The word entering the head of the chain is always the most recent entry.
  always_comb begin
    new_entry.valid = 1'b1;
    new_entry.key   = cur.key;
    new_entry.value = is_put ? cur.value : hit_value;
  end

  // On a hit the cells up to the hit position shift; on an insert the cells up
  // to the limit shift, dropping the least recent entry when evicting.
  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_cell
      lkv_cell_ctrl_t ctrl;
      lkv_entry_t     left;

      assign hit_above[g] = |match[ENTRIES-1:g];
      assign shift[g] = update && (any_hit ? hit_above[g]
                                           : (is_put && (CMP_W'(g) <= limit)));
      assign ctrl.capture = capture;
      assign ctrl.shift   = shift[g];

      if (g == 0) begin : g_head
        assign left = new_entry;
      end else begin : g_body
        assign left = entries[g-1];
      end

      lkv_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (ctrl),
        .cmp_key    (req.key),
        .left_entry (left),
        .entry      (entries[g]),
        .match      (match[g])
      );
    end
  endgenerate

  // Occupied count grows only on an insert that does not evict.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (update && is_put && !any_hit && !evict) begin
      count <= count + CNT_W'(1);
    end
  end

  // Result word for a get, shown for one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= update && (cur.command == CMD_GET);
    end
  end

  always_ff @(posedge clk) begin
    if (update) begin
      rsp.found      <= any_hit;
      rsp.read_value <= any_hit ? hit_value : 32'sd0;
    end
  end

endmodule

// ----- design/lkv_cell.sv -----
// One cell of the recency-ordered chain: holds a key, a value and a valid mark.
// Depends on lkv_pkg for the entry and control types.
module lkv_cell import lkv_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  lkv_cell_ctrl_t ctrl,
  input  logic [31:0]    cmp_key,
  input  lkv_entry_t     left_entry,
  output lkv_entry_t     entry,
  output logic           match
);

  // The valid mark is control state and is cleared at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else if (ctrl.shift) begin
      entry.valid <= left_entry.valid;
    end
  end

  // Key and value move along the chain with the valid mark.
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      entry.key   <= left_entry.key;
      entry.value <= left_entry.value;
    end
  end

  // The broadcast key is compared when a request word is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (ctrl.capture) begin
      match <= entry.valid && (entry.key == cmp_key);
    end
  end

endmodule

// ----- dv/lru_key_value_cache_core_tb.sv -----
// Self-checking testbench for lru_key_value_cache_core: get and put words with
// bursty starts, capacity changes between phases, and a recency-ordered predictor.
// Depends on lkv_pkg and the RTL of the core; reads no files.
module lru_key_value_cache_core_tb import lkv_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // Predicts the cache contents and keeps the results still owed by the core.
  class lru_scoreboard;
    logic [31:0] slot_key[ENTRIES];
    logic [31:0] slot_val[ENTRIES];
    bit          slot_used[ENTRIES];
    int          slot_age[ENTRIES];
    int          held;
    int          cap_limit;
    lkv_rsp_t    owed_q[$];
    int          errors;
    int          words_taken;
    int          gets_seen;
    int          hits_seen;
    int          evictions;

    function new();
      foreach (slot_used[i]) begin
        slot_used[i] = 1'b0;
        slot_age[i]  = 0;
      end
      held        = 0;
      cap_limit   = CAP_RESET;
      errors      = 0;
      words_taken = 0;
      gets_seen   = 0;
      hits_seen   = 0;
      evictions   = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] c);
      cap_limit = c;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // Entries younger than the touched one age by one; the touched one becomes newest.
    function void promote(int idx);
      int old_age;
      old_age = slot_age[idx];
      foreach (slot_used[i])
        if (slot_used[i] && slot_age[i] < old_age) slot_age[i]++;
      slot_age[idx] = 0;
    endfunction

    // Store a new pair, dropping the single oldest entry when the limit is reached.
    function void insert_pair(logic [31:0] k, logic [31:0] v);
      int lim;
      int victim;
      int free_idx;
      lim = (cap_limit < 1) ? 1 : (cap_limit > ENTRIES) ? ENTRIES : cap_limit;
      if (held >= lim) begin
        victim = -1;
        foreach (slot_used[i])
          if (slot_used[i] && (victim < 0 || slot_age[i] > slot_age[victim])) victim = i;
        if (victim >= 0) begin
          slot_used[victim] = 1'b0;
          slot_age[victim]  = 0;
          held--;
          evictions++;
        end
      end
      free_idx = -1;
      foreach (slot_used[i])
        if (!slot_used[i] && free_idx < 0) free_idx = i;
      if (free_idx < 0) return;
      foreach (slot_used[i])
        if (slot_used[i]) slot_age[i]++;
      slot_key[free_idx]  = k;
      slot_val[free_idx]  = v;
      slot_used[free_idx] = 1'b1;
      slot_age[free_idx]  = 0;
      held++;
    endfunction

    // Called for every word the core takes.
    function void note_word(lkv_req_t w);
      int       hit;
      lkv_rsp_t want;
      hit = -1;
      foreach (slot_used[i])
        if (slot_used[i] && slot_key[i] == w.key) hit = i;
      words_taken++;
      if (w.command == CMD_GET) begin
        gets_seen++;
        want = '0;
        if (hit >= 0) begin
          hits_seen++;
          want.found      = 1'b1;
          want.read_value = slot_val[hit];
          promote(hit);
        end
        owed_q.push_back(want);
      end else if (hit >= 0) begin
        slot_val[hit] = w.value;
        promote(hit);
      end else begin
        insert_pair(w.key, w.value);
      end
    endfunction

    function void flag(string what);
      errors++;
      if (errors <= 10) $display("[%0t] MISMATCH %s", $time, what);
    endfunction

    // Called for every result word strobed by the core.
    function void check_word(lkv_rsp_t got);
      lkv_rsp_t want;
      if (owed_q.size() == 0) begin
        flag($sformatf("unexpected result found=%0b read_value=%0d",
                       got.found, got.read_value));
        return;
      end
      want = owed_q.pop_front();
      if (got.found !== want.found)
        flag($sformatf("found: expected %0b, got %0b", want.found, got.found));
      if (got.read_value !== want.read_value)
        flag($sformatf("read_value: expected %0d, got %0d",
                       want.read_value, got.read_value));
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  lkv_req_t         req;
  logic             done;
  lkv_rsp_t         rsp;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_data;

  lru_scoreboard    sb;
  logic [31:0]      key_pool[32];
  int               pool_size;
  int               cap_writes;

  lru_key_value_cache_core DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watch the request and result channels at each edge, using the values from before the edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_word(req);
      if (done) sb.check_word(rsp);
    end
  end

  // Present one word and hold it until the core takes it.
  task automatic send_word(logic cmd, logic [31:0] k, logic [31:0] v);
    lkv_req_t w;
    w.command = cmd;
    w.key     = k;
    w.value   = v;
    start <= 1'b1;
    req   <= w;
    do @(posedge clk); while (busy);
  endtask

  // Let the core drain: all gets answered, then room for a trailing put.
  task automatic wait_idle();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] c);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= c;
    do @(posedge clk); while (!cfg_ready);
    sb.set_capacity(c);
    cap_writes++;
    cfg_valid <= 1'b0;
  endtask

  // Keys mostly come from a small pool so that hits, updates and evictions occur.
  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, pool_size - 1)];
    return $urandom;
  endfunction

  task automatic fill_pool(int n);
    pool_size = n;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
  endtask

  // Bursts of words separated by random gaps; a steady phase never pauses.
  task automatic run_phase(int n_words, bit steady);
    int sent;
    int burst;
    int gap;
    sent = 0;
    while (sent < n_words) begin
      burst = $urandom_range(1, 24);
      for (int j = 0; j < burst && sent < n_words; j++) begin
        send_word($urandom_range(0, 1) ? CMD_PUT : CMD_GET, pick_key(), $urandom);
        sent++;
      end
      gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Hard limit on the whole run.
  initial begin
    #3ms;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int cap_now;
    int settle;
    sb         = new();
    cap_writes = 0;
    rst        = 1'b1;
    start      = 1'b0;
    req        = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty miss, extreme keys and values, update, miss after data.
    send_word(CMD_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    send_word(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_word(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_word(CMD_PUT, 32'h0000_0000, 32'h0000_0000);
    send_word(CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(CMD_GET, 32'h8000_0000, 32'h0000_0000);
    send_word(CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    send_word(CMD_GET, 32'hFFFF_FFFF, 32'h1234_5678);
    send_word(CMD_PUT, 32'h8000_0000, 32'h0000_04D2);
    send_word(CMD_GET, 32'h8000_0000, 32'h0000_0000);
    send_word(CMD_GET, 32'h0000_0005, 32'h0000_0000);

    // Capacity dropped below the number held: each new key evicts only one.
    write_capacity(5'd1);
    send_word(CMD_PUT, 32'h0000_0007, 32'h0000_0046);
    send_word(CMD_GET, 32'h0000_0000, 32'h0000_0000);
    send_word(CMD_GET, 32'h0000_0007, 32'h0000_0000);
    send_word(CMD_PUT, 32'h0000_0008, 32'hDEAD_BEEF);
    send_word(CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    send_word(CMD_GET, 32'h0000_0008, 32'h0000_0000);

    // Small capacity from the full limit downwards.
    write_capacity(5'd16);
    send_word(CMD_PUT, 32'h0000_0011, 32'h0000_0001);
    send_word(CMD_GET, 32'h0000_0007, 32'h0000_0000);
    write_capacity(5'd2);
    send_word(CMD_PUT, 32'h0000_0012, 32'h0000_0002);
    send_word(CMD_PUT, 32'h0000_0013, 32'h0000_0003);
    send_word(CMD_GET, 32'h0000_0012, 32'h0000_0000);
    send_word(CMD_GET, 32'h0000_0011, 32'h0000_0000);

    // Random phases, each with its own capacity and key pool.
    for (int p = 0; p < 10; p++) begin
      cap_now = (p == 0) ? 1 : (p == 1 || p == 9) ? 16 : $urandom_range(1, 16);
      write_capacity(cap_now[CAP_W-1:0]);
      fill_pool($urandom_range(cap_now / 2 + 1, (cap_now + 8 > 32) ? 32 : cap_now + 8));
      run_phase(170, (p % 3) == 2);
    end

    // Drain what is still owed, with a bound, then let the core settle.
    start <= 1'b0;
    settle = 0;
    while (sb.pending() != 0 && settle < 200) begin
      @(posedge clk);
      settle++;
    end
    if (sb.pending() != 0) sb.flag($sformatf("%0d results never arrived", sb.pending()));
    repeat (8) @(posedge clk);

    $display("Covered %0d words: %0d gets (%0d hits), %0d evictions predicted.",
             sb.words_taken, sb.gets_seen, sb.hits_seen, sb.evictions);
    $display("Capacity written %0d times; %0d mismatches counted.", cap_writes, sb.errors);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/lkv_pkg.sv
design/lkv_cell.sv
design/lru_key_value_cache_core.sv
dv/lru_key_value_cache_core_tb.sv
